/* rtl/multi_timer_expiry_queue_defines.svh */
// assertion macros for the timer queue
`ifndef MULTI_TIMER_EXPIRY_QUEUE_DEFINES_SVH
`define MULTI_TIMER_EXPIRY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define MTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MTQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/mteq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mteq_pkg
// types and constants shared by the timer queue modules
// ----------------------------------------------------------------------------
package mteq_pkg;
	localparam int unsigned DefSlots = 16;
	localparam int unsigned RemW = 17;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_START  = 2'd1,
		OP_CANCEL = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RES_ACK    = 2'd0,
		RES_EXPIRY = 2'd1,
		RES_IDLE   = 2'd2,
		RES_RSVD   = 2'd3
	} res_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_SCAN,
		ST_EMIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // start or cancel write of request slot
		logic sub;       // subtract step from all active slots
		logic scan_clr;  // reset scan pointer and found flag
		logic scan_step; // compare one slot
		logic retire;    // emit best and reload or free it
		logic none;      // emit the held expiry as last, or an idle result
		logic ack;       // emit acknowledge
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
		logic found;
	} stat_t;
endpackage

/* rtl/mteq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mteq_ctrl
// sequencer: ack start and cancel; for a tick subtract, scan for earliest pending slot, emit, repeat
// ----------------------------------------------------------------------------
`include "multi_timer_expiry_queue_defines.svh"
module mteq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         op,
	input  mteq_pkg::stat_t    stat,
	output logic               busy,
	output mteq_pkg::cmd_t     cmd
);
	mteq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mteq_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mteq_pkg::ST_IDLE: begin
				if (start && op == mteq_pkg::OP_TICK) state_d = mteq_pkg::ST_SUB;
			end
			mteq_pkg::ST_SUB: state_d = mteq_pkg::ST_SCAN;
			mteq_pkg::ST_SCAN: begin
				if (stat.scan_end) state_d = mteq_pkg::ST_EMIT;
			end
			mteq_pkg::ST_EMIT: begin
				if (stat.found) state_d = mteq_pkg::ST_SCAN;
				else state_d = mteq_pkg::ST_DONE;
			end
			mteq_pkg::ST_DONE: state_d = mteq_pkg::ST_IDLE;
			default: state_d = mteq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			mteq_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start && (op == mteq_pkg::OP_START || op == mteq_pkg::OP_CANCEL);
				cmd.ack = cmd.load;
			end
			mteq_pkg::ST_SUB: begin
				cmd.sub = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			mteq_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			mteq_pkg::ST_EMIT: begin
				cmd.retire = stat.found;
				cmd.scan_clr = 1'b1;
			end
			mteq_pkg::ST_DONE: cmd.none = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	`MTQ_ASSERT_NEXT(a_sub_to_scan, clk, arst_n, state_q == mteq_pkg::ST_SUB, state_q == mteq_pkg::ST_SCAN)
	`MTQ_ASSERT_IMP(a_idle_not_busy, clk, arst_n, state_q == mteq_pkg::ST_IDLE, !busy)
	`MTQ_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.retire, cmd.none, cmd.ack}))
endmodule

/* rtl/mteq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mteq_datapath
// per-slot counters and data, serial min scan, result register
// ----------------------------------------------------------------------------
`include "multi_timer_expiry_queue_defines.svh"
module mteq_datapath #(
	parameter int unsigned TIMER_SLOTS = mteq_pkg::DefSlots
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mteq_pkg::cmd_t  cmd,
	input  logic [7:0]      step,
	input  logic [3:0]      slot,
	input  logic [15:0]     period,
	input  logic [3:0]      timer_kind,
	input  logic [15:0]     user_word,
	input  logic            repeat_req,
	input  logic [1:0]      op,
	output mteq_pkg::stat_t stat,
	output logic            done,
	output logic [1:0]      kind,
	output logic [3:0]      expired_slot,
	output logic [3:0]      expired_kind,
	output logic [15:0]     expired_word,
	output logic            last
);
	localparam int unsigned IdxW = $clog2(TIMER_SLOTS);
	localparam int unsigned CntW = $clog2(TIMER_SLOTS + 1);

	logic signed [mteq_pkg::RemW-1:0] rem_q [TIMER_SLOTS];
	logic [15:0] per_q [TIMER_SLOTS];
	logic [3:0]  tag_q [TIMER_SLOTS];
	logic [15:0] word_q [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] rep_q, act_q, pend_q;

	logic [CntW-1:0] ptr_q;
	logic [IdxW-1:0] best_q;
	logic            found_q;
	logic            any_q;
	logic signed [mteq_pkg::RemW-1:0] best_rem_q;

	logic [IdxW-1:0] pidx;
	logic            in_range;
	logic [IdxW-1:0] sidx;

	assign pidx = ptr_q[IdxW-1:0];
	assign in_range = 32'(slot) < TIMER_SLOTS;
	assign sidx = IdxW'(slot);
	assign stat.scan_end = ptr_q == CntW'(TIMER_SLOTS - 1);
	assign stat.found = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			pend_q <= '0;
			for (int i = 0; i < TIMER_SLOTS; i++) rem_q[i] <= '0;
		end else begin
			if (cmd.load && in_range) begin
				if (op == mteq_pkg::OP_START) begin
					rem_q[sidx] <= mteq_pkg::RemW'({1'b0, period});
					act_q[sidx] <= 1'b1;
				end else begin
					rem_q[sidx] <= '0;
					act_q[sidx] <= 1'b0;
				end
			end
			if (cmd.sub) begin
				for (int i = 0; i < TIMER_SLOTS; i++) begin
					if (act_q[i]) begin
						rem_q[i] <= rem_q[i] - mteq_pkg::RemW'({1'b0, step});
						pend_q[i] <= $signed(rem_q[i] - mteq_pkg::RemW'({1'b0, step})) <= 0;
					end else begin
						pend_q[i] <= 1'b0;
					end
				end
			end
			if (cmd.retire) begin
				pend_q[best_q] <= 1'b0;
				if (rep_q[best_q]) begin
					rem_q[best_q] <= mteq_pkg::RemW'({1'b0, per_q[best_q]});
				end else begin
					rem_q[best_q] <= '0;
					act_q[best_q] <= 1'b0;
				end
			end
		end
	end

	// data fields, written only by start
	always_ff @(posedge clk) begin
		if (cmd.load && in_range && op == mteq_pkg::OP_START) begin
			per_q[sidx] <= period;
			tag_q[sidx] <= timer_kind;
			word_q[sidx] <= user_word;
			rep_q[sidx] <= repeat_req;
		end
	end

	// serial minimum search, one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			found_q <= 1'b0;
			any_q <= 1'b0;
			best_q <= '0;
			best_rem_q <= '0;
		end else begin
			if (cmd.sub) any_q <= 1'b0;
			if (cmd.retire) any_q <= 1'b1;
			if (cmd.scan_clr) begin
				ptr_q <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (pend_q[pidx] && (!found_q || rem_q[pidx] < best_rem_q)) begin
					found_q <= 1'b1;
					best_q <= pidx;
					best_rem_q <= rem_q[pidx];
				end
				if (!stat.scan_end) ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// result register; last of an expiry is known only after the next scan,
	// so expiries are held one round and released when the next round ends
	logic            hold_q;
	logic [3:0]      h_slot_q, h_kind_q;
	logic [15:0]     h_word_q;
	logic            done_q;
	logic [1:0]      kind_q;
	logic [3:0]      slot_q, ekind_q;
	logic [15:0]     word_q2;
	logic            last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hold_q <= 1'b0;
		end else begin
			if (cmd.ack) begin
				done_q <= 1'b1;
			end else if (cmd.retire) begin
				hold_q <= 1'b1;
				done_q <= hold_q;
			end else if (cmd.none) begin
				done_q <= 1'b1;
				hold_q <= 1'b0;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ack) begin
			kind_q <= mteq_pkg::RES_ACK;
			slot_q <= slot;
			ekind_q <= '0;
			word_q2 <= '0;
			last_q <= 1'b1;
		end else if (cmd.retire) begin
			kind_q <= mteq_pkg::RES_EXPIRY;
			slot_q <= h_slot_q;
			ekind_q <= h_kind_q;
			word_q2 <= h_word_q;
			last_q <= 1'b0;
			h_slot_q <= 4'(best_q);
			h_kind_q <= tag_q[best_q];
			h_word_q <= word_q[best_q];
		end else if (cmd.none) begin
			last_q <= 1'b1;
			if (hold_q || any_q) begin
				kind_q <= mteq_pkg::RES_EXPIRY;
				slot_q <= h_slot_q;
				ekind_q <= h_kind_q;
				word_q2 <= h_word_q;
			end else begin
				kind_q <= mteq_pkg::RES_IDLE;
				slot_q <= '0;
				ekind_q <= '0;
				word_q2 <= '0;
			end
		end
	end

	assign done = done_q;
	assign kind = kind_q;
	assign expired_slot = slot_q;
	assign expired_kind = ekind_q;
	assign expired_word = word_q2;
	assign last = last_q;

	`MTQ_ASSERT_IMP(a_retire_pending, clk, arst_n, cmd.retire, pend_q[best_q] && act_q[best_q])
	`MTQ_ASSERT_NEXT(a_ack_last, clk, arst_n, cmd.ack, done && last)
	`MTQ_ASSERT_IMP(a_scan_range, clk, arst_n, cmd.scan_step, ptr_q < CntW'(TIMER_SLOTS))
endmodule

/* rtl/multi_timer_expiry_queue.sv */
`timescale 1ns / 1ps
// start or cancel is acknowledged in the cycle after the request; busy stays low
// a tick runs the serial slot scan (one slot per cycle) that picks each next expiry
// results appear one cycle each on done; the receiver cannot stall them
// reset clears all slots to inactive and tick_step to 1
// ----------------------------------------------------------------------------
// multi_timer_expiry_queue
// timer engine with per-slot counts, expiries in deadline order
// ----------------------------------------------------------------------------
module multi_timer_expiry_queue #(
	parameter int unsigned TIMER_SLOTS = mteq_pkg::DefSlots
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [3:0]  slot,
	input  logic [15:0] period,
	input  logic [3:0]  timer_kind,
	input  logic [15:0] user_word,
	input  logic        repeat_req,
	output logic        done,
	output logic [1:0]  kind,
	output logic [3:0]  expired_slot,
	output logic [3:0]  expired_kind,
	output logic [15:0] expired_word,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [7:0] step_q;
	mteq_pkg::cmd_t  cmd;
	mteq_pkg::stat_t stat;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {24'd0, step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= 8'd1;
		else if (psel && penable && pwrite && paddr == 2'd0) step_q <= pwdata[7:0];
	end

	mteq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op),
		.stat(stat), .busy(busy), .cmd(cmd)
	);

	mteq_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .step(step_q),
		.slot(slot), .period(period), .timer_kind(timer_kind),
		.user_word(user_word), .repeat_req(repeat_req), .op(op),
		.stat(stat), .done(done), .kind(kind), .expired_slot(expired_slot),
		.expired_kind(expired_kind), .expired_word(expired_word), .last(last)
	);
endmodule

/* tb/sv/multi_timer_expiry_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_expiry_queue_tb
// drives start, cancel, no-op and tick requests plus tick_step writes over the
// register port, predicts every ack, idle result and expiry in deadline order, and
// compares each result field by field as it leaves the block
// ----------------------------------------------------------------------------
module multi_timer_expiry_queue_tb;
	import mteq_pkg::*;

	localparam int unsigned SLOTS = DefSlots;
	localparam int unsigned TICK_DRAIN = 2 + (SLOTS + 1) * (SLOTS + 1) + 20;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam logic [1:0] ADDR_TICK_STEP = 2'd0;

	typedef struct packed {
		res_kind_t   rkind;
		logic [3:0]  rslot;
		logic [3:0]  rtag;
		logic [15:0] rword;
		logic        rlast;
	} timer_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [3:0]  slot;
	logic [15:0] period;
	logic [3:0]  timer_kind;
	logic [15:0] user_word;
	logic        repeat_req;
	logic        done;
	logic [1:0]  kind;
	logic [3:0]  expired_slot;
	logic [3:0]  expired_kind;
	logic [15:0] expired_word;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the timer slots
	int          left_count[SLOTS];
	logic [15:0] slot_period[SLOTS];
	logic [3:0]  slot_tag[SLOTS];
	logic [15:0] slot_word[SLOTS];
	logic        slot_repeat[SLOTS];
	logic        slot_live[SLOTS];
	logic [7:0]  step_value;

	timer_result_t pending_results[$];
	int unsigned   fail_count;
	int unsigned   cycle_count;
	bit            no_gaps;

	multi_timer_expiry_queue #(.TIMER_SLOTS(SLOTS)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .slot(slot), .period(period), .timer_kind(timer_kind),
		.user_word(user_word), .repeat_req(repeat_req),
		.done(done), .kind(kind), .expired_slot(expired_slot),
		.expired_kind(expired_kind), .expired_word(expired_word), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic timer_result_t make_result(res_kind_t k, logic [3:0] s,
			logic [3:0] t, logic [15:0] w);
		timer_result_t r;
		r.rkind = k;
		r.rslot = s;
		r.rtag  = t;
		r.rword = w;
		r.rlast = 1'b0;
		return r;
	endfunction

	// works out the results of one accepted request
	task automatic predict_timers(op_t o, logic [3:0] s, logic [15:0] p,
			logic [3:0] t, logic [15:0] w, logic rep);
		bit due[SLOTS];
		int best;
		int n;
		timer_result_t r;
		n = 0;
		if (o == OP_START || o == OP_CANCEL) begin
			if (o == OP_START) begin
				slot_period[s] = p;
				slot_tag[s]    = t;
				slot_word[s]   = w;
				slot_repeat[s] = rep;
				left_count[s]  = int'(p);
				slot_live[s]   = 1'b1;
			end else begin
				slot_live[s]  = 1'b0;
				left_count[s] = 0;
			end
			r = make_result(RES_ACK, s, 4'd0, 16'd0);
			r.rlast = 1'b1;
			pending_results.push_back(r);
			return;
		end
		if (o != OP_TICK)
			return;
		for (int i = 0; i < SLOTS; i++) begin
			due[i] = 1'b0;
			if (slot_live[i]) begin
				left_count[i] -= int'(step_value);
				due[i] = left_count[i] <= 0;
			end
		end
		forever begin
			best = -1;
			for (int i = 0; i < SLOTS; i++)
				if (due[i] && (best < 0 || left_count[i] < left_count[best]))
					best = i;
			if (best < 0)
				break;
			due[best] = 1'b0;
			pending_results.push_back(make_result(RES_EXPIRY, 4'(best), slot_tag[best],
				slot_word[best]));
			n++;
			if (slot_repeat[best]) begin
				left_count[best] = int'(slot_period[best]);
			end else begin
				slot_live[best]  = 1'b0;
				left_count[best] = 0;
			end
		end
		if (n == 0)
			pending_results.push_back(make_result(RES_IDLE, 4'd0, 4'd0, 16'd0));
		pending_results[$].rlast = 1'b1;
	endtask

	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result kind=%0d slot=%0d", $time, kind,
					expired_slot);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (kind != want.rkind || expired_slot != want.rslot
						|| expired_kind != want.rtag || expired_word != want.rword
						|| last != want.rlast) begin
					$display("%0t mismatch expected k=%0d s=%0d t=%0d w=%h l=%0d %s",
						$time, want.rkind, want.rslot, want.rtag, want.rword,
						want.rlast, "");
					$display("%0t          actual   k=%0d s=%0d t=%0d w=%h l=%0d",
						$time, kind, expired_slot, expired_kind, expired_word, last);
					fail_count++;
				end
			end
		end
	end

	// called at a rising edge; returns at the edge after its gap
	task automatic send_request(op_t o, logic [3:0] s, logic [15:0] p,
			logic [3:0] t, logic [15:0] w, logic rep);
		int gap;
		start      <= 1'b1;
		op         <= o;
		slot       <= s;
		period     <= p;
		timer_kind <= t;
		user_word  <= w;
		repeat_req <= rep;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
		predict_timers(o, s, p, t, w, rep);
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_tick();
		send_request(OP_TICK, 4'($urandom), 16'($urandom), 4'($urandom),
			16'($urandom), 1'($urandom));
	endtask

	task automatic send_start(logic [3:0] s, logic [15:0] p, logic rep);
		send_request(OP_START, s, p, 4'($urandom), 16'($urandom), rep);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TICK_DRAIN) @(posedge clk);
	endtask

	task automatic write_tick_step(logic [7:0] v);
		wait_quiet();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TICK_STEP;
		pwdata  <= {24'($urandom_range(0, 16777215)), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		step_value = v;
		@(posedge clk);
	endtask

	task automatic test_commands();
		send_request(OP_START, 4'd0, 16'hFFFF, 4'hF, 16'hFFFF, 1'b1);
		send_request(OP_START, 4'd15, 16'd0, 4'h0, 16'h0000, 1'b0);
		send_request(OP_START, 4'd0, 16'd2, 4'hA, 16'h5A5A, 1'b0);
		send_request(OP_CANCEL, 4'd7, 16'hFFFF, 4'hF, 16'hFFFF, 1'b1);
		send_request(OP_NONE, 4'd3, 16'd1, 4'h1, 16'h1, 1'b1);
		send_request(OP_CANCEL, 4'd15, 16'd0, 4'h0, 16'h0, 1'b0);
		send_tick();
		send_tick();
		send_tick();
	endtask

	task automatic test_ordering();
		send_start(4'd5, 16'd3, 1'b0);
		send_start(4'd2, 16'd3, 1'b0);
		send_start(4'd9, 16'd1, 1'b1);
		send_start(4'd12, 16'd0, 1'b1);
		send_tick();
		send_tick();
		send_tick();
		send_request(OP_CANCEL, 4'd9, 16'd0, 4'd0, 16'd0, 1'b0);
		send_request(OP_CANCEL, 4'd12, 16'd0, 4'd0, 16'd0, 1'b0);
		for (int i = 0; i < SLOTS; i++)
			send_start(4'(i), 16'd1, i[0]);
		send_tick();
		send_tick();
	endtask

	task automatic test_step_extremes();
		write_tick_step(8'd0);
		send_start(4'd4, 16'd0, 1'b1);
		send_start(4'd6, 16'd5, 1'b0);
		send_tick();
		send_tick();
		write_tick_step(8'd255);
		send_start(4'd1, 16'd300, 1'b1);
		send_start(4'd3, 16'd255, 1'b0);
		send_tick();
		send_tick();
	endtask

	task automatic random_phase(int unsigned count, logic [7:0] stp);
		int unsigned pick;
		int unsigned scale;
		logic [15:0] p;
		write_tick_step(stp);
		scale = (stp == 0) ? 1 : 32'(stp);
		no_gaps = ($urandom_range(0, 3) == 0);
		for (int unsigned k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				if ($urandom_range(0, 9) == 0)
					p = 16'($urandom);
				else
					p = 16'($urandom_range(0, scale * 6));
				send_start(4'($urandom), p, $urandom_range(0, 2) == 0);
			end else if (pick < 52) begin
				send_request(OP_CANCEL, 4'($urandom), 16'($urandom), 4'($urandom),
					16'($urandom), 1'($urandom));
			end else if (pick < 55) begin
				send_request(OP_NONE, 4'($urandom), 16'($urandom), 4'($urandom),
					16'($urandom), 1'($urandom));
			end else begin
				send_tick();
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		op         <= OP_TICK;
		slot       <= '0;
		period     <= '0;
		timer_kind <= '0;
		user_word  <= '0;
		repeat_req <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		fail_count  = 0;
		cycle_count = 0;
		no_gaps     = 1'b0;
		step_value  = 8'd1;
		for (int i = 0; i < SLOTS; i++) begin
			left_count[i] = 0;
			slot_live[i]  = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_ordering();
		test_step_extremes();
		random_phase(60, 8'd1);
		random_phase(60, 8'd255);
		random_phase(60, 8'($urandom_range(2, 254)));
		random_phase(60, 8'd0);
		random_phase(60, 8'($urandom_range(1, 20)));

		wait_quiet();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* multi_timer_expiry_queue.f */
+incdir+rtl
rtl/mteq_pkg.sv
rtl/mteq_ctrl.sv
rtl/mteq_datapath.sv
rtl/multi_timer_expiry_queue.sv
tb/sv/multi_timer_expiry_queue_tb.sv
